// ----- hdl/psa_pkg.sv -----
// Shared types and constants of the priority scheduler with aging.
// Used by psa_cell and the top level; no dependencies.
package psa_pkg;

   localparam int TW = 32;
   localparam int SW = 8;
   localparam int CW = 9;

   localparam logic signed [15:0] PRIO_FLOOR = 16'sh8000;
   localparam logic [7:0] THRESHOLD_RESET = 8'd5;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                valid;
      logic signed [15:0]  prio;
      logic [SW-1:0]       slot;
      logic [TW-1:0]       arrival;
      logic [TW-1:0]       burst;
      logic [TW-1:0]       left;
      logic                begun;
      logic [TW-1:0]       first_run;
      logic [CW-1:0]       aged;
   } chain_type;

   typedef struct packed {
      logic                load;
      logic                clear;
      logic                run;
      logic [SW-1:0]       run_slot;
      logic [CW-1:0]       loaded_count;
      logic [TW-1:0]       now;
      logic [TW-1:0]       arrival;
      logic [TW-1:0]       burst;
      logic [7:0]          prio;
      logic [7:0]          threshold;
   } ctl_type;

endpackage

// ----- hdl/psa_cell.sv -----
// One task slot of the scheduler chain: holds the slot, ages it and
// merges it into the running best as the sweep token passes. Uses psa_pkg.
module psa_cell #(
   parameter int INDEX     = 0,
   parameter int TIME_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  psa_pkg::ctl_type    ctl,
   input  logic                token_in,
   input  psa_pkg::chain_type  chain_in,
   output logic                token_out,
   output psa_pkg::chain_type  chain_out
);
   import psa_pkg::*;

   localparam int WW = TIME_BITS + 2;

   logic [TIME_BITS-1:0] arr_ff, bur_ff, left_ff, ref_ff, first_ff;
   logic signed [15:0]   prio_ff, prio_in;
   logic                 begun_ff;
   logic                 token_ff;
   chain_type            chain_ff, chain_in_w;
   logic [TIME_BITS-1:0] now;
   logic                 loaded, eligible, aging, aged_event, take;
   logic                 load_hit, run_hit;
   logic signed [WW-1:0] waiting, thr_ext;

   assign now      = ctl.now[TIME_BITS-1:0];
   assign loaded   = CW'(INDEX) < ctl.loaded_count;
   assign eligible = loaded && (arr_ff <= now) && (left_ff != '0);
   assign waiting  = $signed({2'b00, now}) - $signed({2'b00, ref_ff})
                     - ($signed({2'b00, bur_ff}) - $signed({2'b00, left_ff}));
   assign thr_ext  = $signed(WW'(ctl.threshold));
   assign aging    = eligible && (waiting > thr_ext);
   assign aged_event = aging && (prio_ff != PRIO_FLOOR);
   assign prio_in  = aged_event ? prio_ff - 16'sd1 : prio_ff;
   assign take     = eligible && (!chain_in.valid || (prio_in < chain_in.prio));
   assign load_hit = ctl.load && (ctl.loaded_count == CW'(INDEX));
   assign run_hit  = ctl.run && (ctl.run_slot == SW'(INDEX));

   always_comb begin
      chain_in_w      = chain_in;
      chain_in_w.aged = chain_in.aged + CW'(aged_event);
      if (take) begin
         chain_in_w.valid     = 1'b1;
         chain_in_w.prio      = prio_in;
         chain_in_w.slot      = SW'(INDEX);
         chain_in_w.arrival   = TW'(arr_ff);
         chain_in_w.burst     = TW'(bur_ff);
         chain_in_w.left      = TW'(left_ff);
         chain_in_w.begun     = begun_ff;
         chain_in_w.first_run = TW'(first_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         begun_ff <= 1'b0;
         token_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
         if (ctl.clear || load_hit) begin
            begun_ff <= 1'b0;
         end else if (run_hit) begin
            begun_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_hit) begin
         arr_ff  <= ctl.arrival[TIME_BITS-1:0];
         bur_ff  <= ctl.burst[TIME_BITS-1:0];
         left_ff <= ctl.burst[TIME_BITS-1:0];
         ref_ff  <= ctl.arrival[TIME_BITS-1:0];
         prio_ff <= $signed({8'd0, ctl.prio});
      end else if (token_in) begin
         prio_ff <= prio_in;
         if (aging) begin
            ref_ff <= now;
         end
      end
      if (token_in) begin
         chain_ff <= chain_in_w;
      end
      if (run_hit) begin
         left_ff <= left_ff - TIME_BITS'(1);
         if (!begun_ff) begin
            first_ff <= now;
         end
      end
   end

   assign token_out = token_ff;
   assign chain_out = chain_ff;

endmodule

// ----- hdl/priority_scheduler_with_aging.sv -----
// Priority scheduler with aging: a chain of MAX_TASKS slot cells swept by a token.
// Load, clear and unknown commands complete in the idle state; a tick sends the token
// walking the cell chain once (aging and selection in one visit), then finishes.
// The result sits in an output register; the next item is taken while it waits.
// Synchronous active-high reset clears counters, begun bits and sets the threshold to 5.
// Depends on psa_pkg and psa_cell.
module priority_scheduler_with_aging #(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [15:0] arrival_time, [31:16] burst_time, [39:32] start_priority
   input  logic [39:0]   req_tdata,
   // [1:0] command
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [3:0] task_slot, [19:4] run_priority, [20] finished, [36:21] completion_time,
   // [52:37] turnaround, [68:53] wait_total, [84:69] response, [100:85] aging_events,
   // [101] all_done, [103:102] zero
   output logic [103:0]  rsp_tdata,
   // [0] idle
   output logic [0:0]    rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [7:0]    csr_data
);
   import psa_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_TASKS + 1);
   localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);

   typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FINISH} state_type;

   state_type            state_ff;
   logic                 rsp_valid_ff;
   logic [103:0]         rsp_data_ff, rsp_data_in;
   logic                 rsp_idle_ff;
   logic [CNT_BITS-1:0]  loaded_ff, done_ff, done_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [15:0]          total_ff, total_in;
   logic [7:0]           thr_ff;

   chain_type            chain_w [MAX_TASKS+1];
   logic                 token_w [MAX_TASKS+1];
   ctl_type              ctl;
   chain_type            w;

   logic                 req_acc, start, load_ok, fin_go, finished, all_done;
   cmd_type              cmd;
   logic [31:0]          arr32, bur32, arr_sat, bur_sat;
   logic [TIME_BITS-1:0] arr, bur, tat, wt, rt, fr;
   logic [31:0]          ct32, tat32, wt32, rt32, slot32;
   logic [16:0]          tsum;

   assign cmd       = cmd_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc   = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign arr32     = {16'd0, req_tdata[15:0]};
   assign bur32     = {16'd0, req_tdata[31:16]};
   assign arr_sat   = (arr32 > TIME_MAX) ? TIME_MAX : arr32;
   assign bur_sat   = (bur32 > TIME_MAX) ? TIME_MAX : bur32;
   assign load_ok   = (loaded_ff != CNT_BITS'(MAX_TASKS)) && (bur_sat != 32'd0);
   assign start     = req_acc && (cmd == CMD_TICK);
   assign w         = chain_w[MAX_TASKS];
   assign fin_go    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ctl.load         = req_acc && (cmd == CMD_LOAD) && load_ok;
      ctl.clear        = req_acc && (cmd == CMD_CLEAR);
      ctl.run          = fin_go && w.valid;
      ctl.run_slot     = w.slot;
      ctl.loaded_count = CW'(loaded_ff);
      ctl.now          = TW'(now_ff);
      ctl.arrival      = arr_sat;
      ctl.burst        = bur_sat;
      ctl.prio         = req_tdata[39:32];
      ctl.threshold    = thr_ff;
   end

   assign chain_w[0] = '0;
   assign token_w[0] = start;

   for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
      psa_cell #(
         .INDEX     (k),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .token_in  (token_w[k]),
         .chain_in  (chain_w[k]),
         .token_out (token_w[k+1]),
         .chain_out (chain_w[k+1])
      );
   end

   always_comb begin
      now_in   = (now_ff == TIME_MAX[TIME_BITS-1:0]) ? now_ff : now_ff + TIME_BITS'(1);
      arr      = w.arrival[TIME_BITS-1:0];
      bur      = w.burst[TIME_BITS-1:0];
      tat      = now_in - arr;
      wt       = (tat >= bur) ? tat - bur : '0;
      fr       = w.begun ? w.first_run[TIME_BITS-1:0] : now_ff;
      rt       = fr - arr;
      finished = w.valid && (w.left[TIME_BITS-1:0] == TIME_BITS'(1));
      tsum     = {1'b0, total_ff} + 17'(w.aged);
      total_in = tsum[16] ? 16'hFFFF : tsum[15:0];
      done_in  = done_ff + CNT_BITS'(finished);
      all_done = (done_in == loaded_ff);
      ct32     = finished ? 32'(now_in) : 32'd0;
      tat32    = finished ? 32'(tat) : 32'd0;
      wt32     = finished ? 32'(wt) : 32'd0;
      rt32     = finished ? 32'(rt) : 32'd0;
      slot32   = w.valid ? 32'(w.slot) : 32'd0;
      rsp_data_in = {2'b00, all_done, total_in, rt32[15:0], wt32[15:0], tat32[15:0],
                     ct32[15:0], finished, (w.valid ? w.prio : 16'sd0), slot32[3:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         loaded_ff    <= '0;
         done_ff      <= '0;
         now_ff       <= '0;
         total_ff     <= '0;
         thr_ff       <= THRESHOLD_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_tready && !fin_go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  case (cmd)
                     CMD_LOAD: begin
                        if (load_ok) begin
                           loaded_ff <= loaded_ff + CNT_BITS'(1);
                        end
                     end
                     CMD_TICK: begin
                        state_ff <= S_SWEEP;
                     end
                     CMD_CLEAR: begin
                        loaded_ff <= '0;
                        done_ff   <= '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_SWEEP: begin
               if (token_w[MAX_TASKS]) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (fin_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_data_in;
                  rsp_idle_ff  <= !w.valid;
                  now_ff       <= now_in;
                  total_ff     <= total_in;
                  done_ff      <= done_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idle_ff;

endmodule

// ----- hdl/psa_checker.sv -----
// Port-level checks for the priority scheduler with aging, bound to the top level.
// Depends on priority_scheduler_with_aging ports only.
module psa_checker (
   input logic          clock,
   input logic          reset,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [103:0]  rsp_tdata,
   input logic [0:0]    rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled transfer changed");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[20:0] == 21'd0)
      else $error("idle result carries a task");

   a_metrics_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[20] |-> rsp_tdata[84:21] == 64'd0)
      else $error("metrics set without completion");

   a_wait_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20] |-> rsp_tdata[68:53] <= rsp_tdata[52:37])
      else $error("waiting time exceeds turnaround");

endmodule

bind priority_scheduler_with_aging psa_checker u_psa_checker (.*);
